/* sv/assert_macros.svh */
// Assertion macros shared by the line upscaler modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Whenever pre holds, post must hold in the same cycle.
`define ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

/* sv/llu_pkg.sv */
// ----------------------------------------------------------------------------
// llu_pkg
// Shared constants, types and the cubic weight table of the line upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package llu_pkg;

    localparam int UPSCALE = 10;
    localparam int WIN     = 4;
    localparam int SW      = 8;
    localparam int PIXW    = 10;
    localparam int PAW     = $clog2(WIN);
    localparam int KW      = $clog2(UPSCALE);

    // Configuration port.
    localparam int   ADDRW          = 3;
    localparam int   DATAW          = 32;
    localparam logic REG_CUBIC_MODE = 1'b0;

    // Cubic path: offsets e = pos*UPSCALE + k over the three intervals.
    localparam int     NE    = 3 * UPSCALE;
    localparam int     EW    = $clog2(NE);
    localparam int     CW    = $clog2(3 * (3 * UPSCALE) ** 3 + 1) + 1;
    localparam int     PCW   = SW + 1 + CW;
    localparam int     XW    = PCW + 2;
    localparam int     CS    = XW - 1;
    localparam longint CDIV  = 6 * longint'(UPSCALE) ** 3;
    localparam longint CMUL  = (longint'(1) << CS) / CDIV;
    localparam int     CMW   = $clog2(CMUL + 1);
    localparam int     QCW   = CS - $clog2(CDIV) + 1;

    // Linear path: products a*(F-k) and b*k, divided by UPSCALE.
    localparam int     PW    = $clog2(255 * UPSCALE + 1);
    localparam int     LS    = PW;
    localparam longint LMUL  = (longint'(1) << LS) / UPSCALE;
    localparam int     LMW   = $clog2(LMUL + 1);

    // Queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef logic signed [CW-1:0] coef_t;
    typedef coef_t [WIN-1:0]      coef_row_t;
    typedef coef_row_t [NE-1:0]   coef_tab_t;

    // One accepted sample's work: the window it saw, the mode, which
    // intervals to interpolate, which held samples to pass unchanged, and
    // whether the newest sample closes the line.
    typedef struct packed {
        logic [WIN-1:0][SW-1:0] win;
        logic                   cubic;
        logic [WIN-2:0]         seg;
        logic [WIN-2:0]         raw;
        logic                   fin;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Lagrange numerators times the node weights -1, 3, -3, 1.
    function automatic coef_tab_t build_coef_tab();
        coef_tab_t tab;
        longint    num;
        longint    w;
        for (int e = 0; e < NE; e++) begin
            for (int i = 0; i < WIN; i++) begin
                num = 1;
                for (int j = 0; j < WIN; j++) begin
                    if (j != i) begin
                        num = num * (longint'(e) - longint'(j) * UPSCALE);
                    end
                end
                w = (i == 0) ? -1 : (i == 1) ? 3 : (i == 2) ? -3 : 1;
                tab[e][i] = CW'(w * num);
            end
        end
        return tab;
    endfunction

    localparam coef_tab_t COEF_TAB = build_coef_tab();

endpackage

`default_nettype wire

/* sv/llu_front.sv */
// ----------------------------------------------------------------------------
// llu_front
// Keeps the four-sample window and line count, and turns each accepted
// sample that brings work into a work descriptor for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module llu_front import llu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cubic_mode,
    input  logic [SW-1:0] sample,
    input  logic          line_end,
    input  logic          sample_valid,
    output logic          sample_ready,
    input  q_status_t     q_stat,
    output logic          push,
    output desc_t         desc
);

    logic [WIN-1:0][SW-1:0] win_reg;
    logic [WIN-1:0][SW-1:0] win_next;
    logic [2:0]             seen_reg;
    logic [2:0]             seen_next;
    logic                   accept;
    logic                   has_work;

    assign sample_ready = !q_stat.full;
    assign accept       = sample_valid && sample_ready;
    assign win_next     = {sample, win_reg[WIN-1:1]};
    assign push         = accept && has_work;

    always_comb
    begin
        desc       = '0;
        desc.win   = win_next;
        desc.cubic = cubic_mode;
        has_work   = 1'b0;
        seen_next  = seen_reg;
        if (seen_reg < 3'(WIN - 1))
        begin
            if (!line_end)
            begin
                seen_next = seen_reg + 3'd1;
            end
            else
            begin
                // A short line: only the newest held samples take part.
                for (int i = 0; i < WIN - 1; i++)
                begin
                    if (i + int'(seen_reg) >= WIN - 1)
                    begin
                        if (seen_reg != 3'd0 && !cubic_mode)
                        begin
                            desc.seg[i] = 1'b1;
                        end
                        else
                        begin
                            desc.raw[i] = 1'b1;
                        end
                    end
                end
                desc.fin  = 1'b1;
                has_work  = 1'b1;
                seen_next = '0;
            end
        end
        else
        begin
            // The fourth sample opens the first two intervals at once.
            desc.seg[0] = (seen_reg == 3'(WIN - 1));
            desc.seg[1] = 1'b1;
            desc.seg[2] = line_end;
            desc.fin    = line_end;
            has_work    = 1'b1;
            seen_next   = line_end ? 3'd0 : 3'(WIN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
        end
    end

    `ASSERT_NEVER(a_seen_saturates, seen_reg > 3'(WIN), "sample count ran past four")

endmodule

`default_nettype wire

/* sv/llu_queue.sv */
// ----------------------------------------------------------------------------
// llu_queue
// Short descriptor queue that lets the front and back ends stall apart.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module llu_queue import llu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  desc_t     din,
    input  logic      pop,
    output desc_t     dout,
    output q_status_t q_stat
);

    desc_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;

    assign dout         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QAW + 1)'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_NEVER(a_no_overflow, push && q_stat.full && !pop, "push into a full queue")
    `ASSERT_NEVER(a_no_underflow, pop && q_stat.empty, "pop from an empty queue")

endmodule

`default_nettype wire

/* sv/llu_back.sv */
// ----------------------------------------------------------------------------
// llu_back
// Walks the head descriptor one pixel per cycle unless pixel_ready stalls it
// and computes each pixel in a short pipeline: coefficient lookup, products,
// sum, reciprocal scaling and a final correction into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module llu_back import llu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  desc_t                  head,
    input  q_status_t              q_stat,
    output logic                   pop,
    output logic                   pixel_valid,
    input  logic                   pixel_ready,
    output logic signed [PIXW-1:0] pixel,
    output logic                   last_of_line
);

    typedef struct packed {
        logic          byp;
        logic [SW-1:0] bval;
        logic          last;
        logic          cub;
    } ctl_t;

    // Sequencer.
    logic [WIN-1:0] done_reg;
    logic [WIN-1:0] done_next;
    logic [KW-1:0]  k_reg;
    logic [KW-1:0]  k_next;
    logic [WIN-1:0] act;
    logic [WIN-1:0] pending;
    logic [WIN-1:0] cur_oh;
    logic [WIN-1:0] rest;
    logic [PAW-1:0] cur_pos;
    logic           is_seg;
    logic           elem_done;
    logic           adv;
    logic           issue;
    logic [EW-1:0]  e_idx;

    // Pipeline stages.
    logic                   v0_reg, v1_reg, v2_reg, v3_reg;
    ctl_t                   c0_reg, c1_reg, c2_reg, c3_reg;
    ctl_t                   c0_next;
    logic [KW-1:0]          k0_reg;
    logic [SW-1:0]          a0_reg, b0_reg;
    logic [WIN-1:0][SW-1:0] s0_reg;
    coef_row_t              coef0_reg;

    logic signed [PCW-1:0]  cp1_reg  [WIN];
    logic signed [PCW-1:0]  cp1_next [WIN];
    logic [PW-1:0]          pa1_reg, pb1_reg, pa1_next, pb1_next;
    logic [KW:0]            fk;

    logic signed [XW-1:0]   x2_reg, x2_next;
    logic [PW-1:0]          pa2_reg, pb2_reg;
    logic [SW-1:0]          qa2_reg, qb2_reg, qa2_next, qb2_next;
    logic [PW+LMW-1:0]      pam, pbm;

    logic                   neg3_reg, neg3_next;
    logic [XW-2:0]          ax3_reg, ax3_next;
    logic [QCW-1:0]         cq3_reg, cq3_next;
    logic [SW:0]            lin3_reg, lin3_next;
    logic signed [XW-1:0]   absx;
    logic [XW-2+CMW:0]      cm;
    logic [PW-1:0]          qfa, qfb, ra, rb;
    logic [SW:0]            qa_c, qb_c;

    logic [XW-2:0]          cqd;
    logic [XW-2:0]          rem;
    logic [QCW:0]           cq;
    logic [QCW:0]           sres;

    logic                   pixel_valid_reg;
    logic signed [PIXW-1:0] pixel_reg, pixel_next;
    logic                   last_reg;

    // ---------------------------------------------------------------- issue
    assign act     = {head.fin, head.seg | head.raw};
    assign pending = act & ~done_reg;
    assign cur_oh  = pending & (~pending + WIN'(1));
    assign rest    = pending & ~cur_oh;

    always_comb
    begin
        cur_pos = '0;
        for (int i = 0; i < WIN; i++)
        begin
            if (cur_oh[i])
            begin
                cur_pos = PAW'(i);
            end
        end
    end

    assign is_seg    = |(cur_oh[WIN-2:0] & head.seg);
    assign elem_done = !is_seg || (k_reg == KW'(UPSCALE - 1));
    assign adv       = !pixel_valid_reg || pixel_ready;
    assign issue     = adv && !q_stat.empty;
    assign pop       = issue && elem_done && (rest == '0);
    assign e_idx     = is_seg ? EW'(int'(cur_pos) * UPSCALE + int'(k_reg)) : '0;

    always_comb
    begin
        // The left sample of an interval, a passed sample and the closing
        // sample all go straight through.
        c0_next.byp  = !is_seg || (k_reg == '0);
        c0_next.bval = head.win[cur_pos];
        c0_next.last = cur_oh[WIN-1];
        c0_next.cub  = head.cubic;
        done_next    = done_reg;
        k_next       = k_reg;
        if (pop)
        begin
            done_next = '0;
            k_next    = '0;
        end
        else if (elem_done)
        begin
            done_next = done_reg | cur_oh;
            k_next    = '0;
        end
        else
        begin
            k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
            k_reg    <= '0;
        end
        else if (issue)
        begin
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    // ---------------------------------------------------------- arithmetic
    always_comb
    begin
        fk       = (KW + 1)'(UPSCALE) - {1'b0, k0_reg};
        pa1_next = PW'(a0_reg * fk);
        pb1_next = PW'(b0_reg * k0_reg);
        for (int i = 0; i < WIN; i++)
        begin
            cp1_next[i] = $signed({1'b0, s0_reg[i]}) * $signed(coef0_reg[i]);
        end
    end

    always_comb
    begin
        x2_next = '0;
        for (int i = 0; i < WIN; i++)
        begin
            x2_next = x2_next + XW'(cp1_reg[i]);
        end
        pam      = pa1_reg * LMW'(LMUL);
        pbm      = pb1_reg * LMW'(LMUL);
        qa2_next = SW'(pam >> LS);
        qb2_next = SW'(pbm >> LS);
    end

    always_comb
    begin
        // Magnitude times the reciprocal of 6*F^3; the estimate is at most
        // one below the true quotient.
        neg3_next = x2_reg[XW-1];
        absx      = neg3_next ? -x2_reg : x2_reg;
        ax3_next  = absx[XW-2:0];
        cm        = ax3_next * CMW'(CMUL);
        cq3_next  = QCW'(cm >> CS);
        qfa       = PW'(qa2_reg) * PW'(UPSCALE);
        qfb       = PW'(qb2_reg) * PW'(UPSCALE);
        ra        = pa2_reg - qfa;
        rb        = pb2_reg - qfb;
        qa_c      = {1'b0, qa2_reg} + (SW + 1)'(ra >= PW'(UPSCALE));
        qb_c      = {1'b0, qb2_reg} + (SW + 1)'(rb >= PW'(UPSCALE));
        lin3_next = qa_c + qb_c;
    end

    always_comb
    begin
        cqd  = (XW - 1)'(cq3_reg) * (XW - 1)'(CDIV);
        rem  = ax3_reg - cqd;
        cq   = {1'b0, cq3_reg} + (QCW + 1)'(rem >= (XW - 1)'(CDIV));
        sres = neg3_reg ? -cq : cq;
        if (c3_reg.byp)
        begin
            pixel_next = PIXW'({1'b0, c3_reg.bval});
        end
        else if (c3_reg.cub)
        begin
            pixel_next = sres[PIXW-1:0];
        end
        else
        begin
            pixel_next = PIXW'({1'b0, lin3_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg    <= c0_next;
            k0_reg    <= k_reg;
            a0_reg    <= head.win[cur_pos];
            b0_reg    <= head.win[PAW'(cur_pos + 1'b1)];
            s0_reg    <= head.win;
            coef0_reg <= COEF_TAB[e_idx];

            c1_reg  <= c0_reg;
            cp1_reg <= cp1_next;
            pa1_reg <= pa1_next;
            pb1_reg <= pb1_next;

            c2_reg  <= c1_reg;
            x2_reg  <= x2_next;
            pa2_reg <= pa1_reg;
            pb2_reg <= pb1_reg;
            qa2_reg <= qa2_next;
            qb2_reg <= qb2_next;

            c3_reg   <= c2_reg;
            neg3_reg <= neg3_next;
            ax3_reg  <= ax3_next;
            cq3_reg  <= cq3_next;
            lin3_reg <= lin3_next;

            pixel_reg <= pixel_next;
            last_reg  <= c3_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            pixel_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg          <= issue;
            v1_reg          <= v0_reg;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            pixel_valid_reg <= v3_reg;
        end
    end

    assign pixel_valid  = pixel_valid_reg;
    assign pixel        = pixel_reg;
    assign last_of_line = last_reg;

    `ASSERT_NEVER(a_head_has_work, !q_stat.empty && pending == '0, "queued item with no pixels")

endmodule

`default_nettype wire

/* sv/lagrange_line_upscaler.sv */
// ----------------------------------------------------------------------------
// lagrange_line_upscaler
// One-dimensional line upsampler by UPSCALE with linear or four-point
// cubic Lagrange interpolation, selected by a configuration register.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                    payload
//   sample    in         sample_valid / sample_ready  sample, line_end
//   pixel     out        pixel_valid / pixel_ready    pixel, last_of_line
//   config    in         APB write, pready tied high  cubic_mode at 0x0
//
// Each sample yields up to 3*UPSCALE+1 pixels; the back end issues one pixel
// per cycle unless the pixel output stalls. Samples are taken while the
// two-entry descriptor queue has room; a pixel issued from its head passes
// the lookup, product, sum, scaling and output registers in that order.
// A stalled pixel output freezes the whole arithmetic pipeline.
// Reset clears the window, the line count and the queue; cubic_mode resets
// to cubic.
// ----------------------------------------------------------------------------
`default_nettype none

module lagrange_line_upscaler import llu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDRW-1:0]       paddr,
    input  logic [DATAW-1:0]       pwdata,
    output logic [DATAW-1:0]       prdata,
    output logic                   pready,
    input  logic [SW-1:0]          sample,
    input  logic                   line_end,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    output logic signed [PIXW-1:0] pixel,
    output logic                   last_of_line,
    output logic                   pixel_valid,
    input  logic                   pixel_ready
);

    logic      cubic_mode_reg;
    logic      reg_index;
    logic      push;
    logic      pop;
    desc_t     desc_in;
    desc_t     desc_head;
    q_status_t q_stat;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDRW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cubic_mode_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && reg_index == REG_CUBIC_MODE)
        begin
            cubic_mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_CUBIC_MODE: prdata = DATAW'(cubic_mode_reg);
            default:        prdata = '0;
        endcase
    end

    llu_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cubic_mode   (cubic_mode_reg),
        .sample       (sample),
        .line_end     (line_end),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .q_stat       (q_stat),
        .push         (push),
        .desc         (desc_in)
    );

    llu_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (desc_in),
        .pop    (pop),
        .dout   (desc_head),
        .q_stat (q_stat)
    );

    llu_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (desc_head),
        .q_stat       (q_stat),
        .pop          (pop),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .last_of_line (last_of_line)
    );

endmodule

`default_nettype wire
